@@ rtl/ikw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikw_pkg
// Shared types, constants and helper functions of the ISAAC keystream window.
// ----------------------------------------------------------------------------
package ikw_pkg;

  localparam int          WINDOW_DEPTH_DEF = 128;
  localparam logic [31:0] GOLDEN           = 32'h9E3779B9;
  localparam logic [7:0]  LIMIT_RESET      = 8'd100;
  localparam logic [32:0] BASE_START       = 33'd2;

  typedef enum logic [1:0] {
    ACT_GET     = 2'd0,
    ACT_PURGE   = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  localparam logic [0:0] RIDX_SEED  = 1'b0;
  localparam logic [0:0] RIDX_LIMIT = 1'b1;

  typedef struct packed {
    logic restart;
    logic next;
  } gen_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] word;
  } gen_rsp_t;

  // Shift of one golden mix step: odd steps shift right, even steps left.
  function automatic logic [31:0] gm_shift(input logic [2:0] k, input logic [31:0] nb);
    logic [31:0] r;
    case (k)
      3'd0:    r = nb << 11;
      3'd1:    r = nb >> 2;
      3'd2:    r = nb << 8;
      3'd3:    r = nb >> 16;
      3'd4:    r = nb << 10;
      3'd5:    r = nb >> 4;
      3'd6:    r = nb << 8;
      default: r = nb >> 9;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] scr_shift(input logic [1:0] sel, input logic [31:0] a);
    logic [31:0] r;
    case (sel)
      2'd0:    r = a << 13;
      2'd1:    r = a >> 6;
      2'd2:    r = a << 2;
      default: r = a >> 16;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/ikw_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikw_if
// Valid/ready channels for requests and results of the keystream window.
// ----------------------------------------------------------------------------
interface ikw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] sequence_req;

  modport source (output valid, action, sequence_req, input ready);
  modport sink   (input valid, action, sequence_req, output ready);
endinterface

interface ikw_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic        hit;

  modport source (output valid, word, hit, input ready);
  modport sink   (input valid, word, hit, output ready);
endinterface

@@ rtl/ikw_gen.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikw_gen
// ISAAC generator: mix memory and result memory with a read-modify-write
// sequencer for seeding, scrambling and handing out words.
// ----------------------------------------------------------------------------
module ikw_gen
  import ikw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] seed,
  input  gen_req_t    req,
  output gen_rsp_t    rsp
);

  typedef enum logic [3:0] {
    G_IDLE, G_INIT, G_MIX, G_STORE, G_LOAD, G_SCI,
    G_S0, G_S1, G_S2, G_S3, G_S4, G_RD0, G_RD1
  } gst_t;

  gst_t        state_r;
  logic [31:0] v_r [8];
  logic [31:0] v_step [8];
  logic [31:0] t_mix;
  logic [2:0]  k_r;
  logic [1:0]  mixn_r;
  logic [4:0]  grp_r;
  logic        pass_r;
  logic [3:0]  ld_r;
  logic [3:0]  ld_m1;
  logic [7:0]  si_r;
  logic [31:0] x_r, y_r;
  logic        fwd_r;
  logic [31:0] acc_a_r, acc_b_r, acc_c_r;
  logic [7:0]  rp_r;
  logic [31:0] word_r;
  logic        done_r;

  logic [31:0] mix_mem [256];
  logic [31:0] res_mem [256];
  logic [31:0] mm_rdata_r, rs_rdata_r;
  logic        mm_re, mm_we, rs_re, rs_we;
  logic [7:0]  mm_raddr, mm_waddr, rs_raddr;
  logic [31:0] mm_wdata;
  logic [31:0] y_nxt, b_nxt;

  assign ld_m1 = ld_r - 4'd1;
  assign y_nxt = mm_rdata_r + acc_a_r + acc_b_r;
  assign b_nxt = (fwd_r ? y_r : mm_rdata_r) + x_r;

  always_comb begin
    v_step = v_r;
    t_mix = v_r[k_r] ^ gm_shift(k_r, v_r[k_r + 3'd1]);
    v_step[k_r] = t_mix;
    v_step[k_r + 3'd3] = v_r[k_r + 3'd3] + t_mix;
    v_step[k_r + 3'd1] = v_r[k_r + 3'd1] + v_r[k_r + 3'd2];
  end

  always_comb begin
    mm_re    = 1'b0;
    mm_raddr = '0;
    mm_we    = 1'b0;
    mm_waddr = '0;
    mm_wdata = '0;
    rs_re    = 1'b0;
    rs_raddr = rp_r;
    rs_we    = 1'b0;
    case (state_r)
      G_STORE: begin
        mm_we    = 1'b1;
        mm_waddr = {grp_r, k_r};
        mm_wdata = v_r[k_r];
      end
      G_LOAD: begin
        mm_re    = !ld_r[3];
        mm_raddr = {grp_r, ld_r[2:0]};
      end
      G_S0: begin
        mm_re    = 1'b1;
        mm_raddr = si_r;
      end
      G_S1: begin
        mm_re    = 1'b1;
        mm_raddr = si_r + 8'd128;
      end
      G_S2: begin
        mm_re    = 1'b1;
        mm_raddr = x_r[9:2];
      end
      G_S3: begin
        mm_we    = 1'b1;
        mm_waddr = si_r;
        mm_wdata = y_nxt;
        mm_re    = 1'b1;
        mm_raddr = y_nxt[17:10];
      end
      G_S4:    rs_we = 1'b1;
      G_RD0:   rs_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mm_we) mix_mem[mm_waddr] <= mm_wdata;
    if (mm_re) mm_rdata_r <= mix_mem[mm_raddr];
    if (rs_we) res_mem[si_r] <= b_nxt;
    if (rs_re) rs_rdata_r <= res_mem[rs_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
      acc_a_r <= '0;
      acc_b_r <= '0;
      acc_c_r <= '0;
      rp_r    <= 8'd255;
      done_r  <= 1'b0;
      k_r     <= '0;
      mixn_r  <= '0;
      grp_r   <= '0;
      pass_r  <= 1'b0;
      ld_r    <= '0;
      si_r    <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        G_IDLE: begin
          if (req.restart) begin
            acc_a_r <= seed;
            acc_b_r <= seed;
            acc_c_r <= seed;
            for (int j = 0; j < 8; j++) v_r[j] <= GOLDEN;
            k_r     <= '0;
            mixn_r  <= '0;
            state_r <= G_INIT;
          end else if (req.next) begin
            state_r <= G_RD0;
          end
        end
        G_INIT: begin
          v_r <= v_step;
          k_r <= k_r + 3'd1;
          if (k_r == 3'd7) begin
            if (mixn_r == 2'd3) begin
              pass_r  <= 1'b0;
              grp_r   <= '0;
              state_r <= G_MIX;
            end else begin
              mixn_r <= mixn_r + 2'd1;
            end
          end
        end
        G_MIX: begin
          v_r <= v_step;
          k_r <= k_r + 3'd1;
          if (k_r == 3'd7) state_r <= G_STORE;
        end
        G_STORE: begin
          k_r <= k_r + 3'd1;
          if (k_r == 3'd7) begin
            ld_r <= '0;
            if (grp_r == 5'd31) begin
              grp_r <= '0;
              if (pass_r) begin
                state_r <= G_SCI;
              end else begin
                pass_r  <= 1'b1;
                state_r <= G_LOAD;
              end
            end else begin
              grp_r   <= grp_r + 5'd1;
              state_r <= pass_r ? G_LOAD : G_MIX;
            end
          end
        end
        G_LOAD: begin
          ld_r <= ld_r + 4'd1;
          if (ld_r != 4'd0) v_r[ld_m1[2:0]] <= v_r[ld_m1[2:0]] + mm_rdata_r;
          if (ld_r == 4'd8) state_r <= G_MIX;
        end
        G_SCI: begin
          acc_c_r <= acc_c_r + 32'd1;
          acc_b_r <= acc_b_r + acc_c_r + 32'd1;
          si_r    <= '0;
          state_r <= G_S0;
        end
        G_S0: state_r <= G_S1;
        G_S1: begin
          x_r     <= mm_rdata_r;
          state_r <= G_S2;
        end
        G_S2: begin
          acc_a_r <= (acc_a_r ^ scr_shift(si_r[1:0], acc_a_r)) + mm_rdata_r;
          state_r <= G_S3;
        end
        G_S3: begin
          // The second read may hit the entry written in this same cycle.
          y_r     <= y_nxt;
          fwd_r   <= (y_nxt[17:10] == si_r);
          state_r <= G_S4;
        end
        G_S4: begin
          acc_b_r <= b_nxt;
          si_r    <= si_r + 8'd1;
          if (si_r == 8'd255) begin
            rp_r    <= 8'd255;
            done_r  <= 1'b1;
            state_r <= G_IDLE;
          end else begin
            state_r <= G_S0;
          end
        end
        G_RD0: state_r <= G_RD1;
        G_RD1: begin
          word_r <= rs_rdata_r;
          if (rp_r == 8'd0) begin
            state_r <= G_SCI;
          end else begin
            rp_r    <= rp_r - 8'd1;
            done_r  <= 1'b1;
            state_r <= G_IDLE;
          end
        end
        default: state_r <= G_IDLE;
      endcase
    end
  end

  assign rsp.busy = (state_r != G_IDLE);
  assign rsp.done = done_r;
  assign rsp.word = word_r;

endmodule

@@ rtl/isaac_keystream_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isaac_keystream_window
// ISAAC word generator behind a ring of words addressed by sequence number.
// ----------------------------------------------------------------------------
// channel   direction  contents
// in_ch     sink       action, sequence_req
// out_ch    source     word, hit
// APB       slave      seed_value at 0x0, window_limit at 0x4
//
// One request at a time. A get already in the ring is read from it; a get
// beyond the fill pulls new words from the generator first, and each
// 256th word adds a scramble of the mix memory, bound by its single read
// port. Reset is synchronous; a finished word waits in the output register
// while the next request is taken.
// ----------------------------------------------------------------------------
module isaac_keystream_window
  import ikw_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
)(
  input  logic        clk,
  input  logic        rst_n,
  ikw_in_if.sink      in_ch,
  ikw_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FW = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [2:0] {
    T_IDLE, T_EVAL, T_CHK, T_GWAIT, T_RD, T_RWAIT, T_DONE
  } tst_t;

  tst_t          state_r;
  logic [31:0]   seed_r;
  logic [7:0]    limit_r;
  logic [1:0]    act_r;
  logic [31:0]   seq_r;
  logic [32:0]   base_r;
  logic [FW-1:0] fill_r;
  logic [IW-1:0] head_r;
  logic [FW-1:0] off_r;
  logic [31:0]   res_word_r;
  logic          res_hit_r;
  logic          out_valid_r;
  logic [31:0]   out_word_r;
  logic          out_hit_r;

  logic [31:0]   win_mem [WINDOW_DEPTH];
  logic [31:0]   win_rdata_r;

  gen_req_t      gen_req;
  gen_rsp_t      gen_rsp;

  logic [33:0]   seq34, base34, lim34, dep34, lim_eff, diff;
  logic          in_get, in_pur;
  logic [FW-1:0] off_w, n_w;
  logic [IW-1:0] head_n, slot_w, slot_r;
  logic          need_word;

  function automatic logic [IW-1:0] ring(input logic [FW:0] s);
    logic [FW:0] r;
    r = (s >= (FW+1)'(WINDOW_DEPTH)) ? s - (FW+1)'(WINDOW_DEPTH) : s;
    return r[IW-1:0];
  endfunction

  ikw_gen u_gen (
    .clk   (clk),
    .rst_n (rst_n),
    .seed  (seed_r),
    .req   (gen_req),
    .rsp   (gen_rsp)
  );

  assign seq34   = {2'b00, seq_r};
  assign base34  = {1'b0, base_r};
  assign lim34   = {26'd0, limit_r};
  assign dep34   = 34'(WINDOW_DEPTH);
  assign lim_eff = (lim34 < dep34) ? lim34 : dep34;
  assign in_get  = (base_r != '0) && (seq34 >= base34) && (seq34 < base34 + lim_eff);
  assign in_pur  = (base_r != '0) && (seq34 >= base34) &&
                   (seq34 < base34 + 34'(fill_r));
  assign diff    = seq34 - base34;
  assign off_w   = diff[FW-1:0];
  assign n_w     = off_w + FW'(1);
  assign head_n  = ring((FW+1)'(head_r) + (FW+1)'(n_w));
  assign slot_w  = ring((FW+1)'(head_r) + (FW+1)'(fill_r));
  assign slot_r  = ring((FW+1)'(head_r) + (FW+1)'(off_r));
  assign need_word = (off_r >= fill_r);

  assign gen_req.restart = (state_r == T_EVAL) && (act_r == ACT_RESTART);
  assign gen_req.next    = (state_r == T_CHK) && need_word;

  always_ff @(posedge clk) begin
    if ((state_r == T_GWAIT) && gen_rsp.done) win_mem[slot_w] <= gen_rsp.word;
    if ((state_r == T_CHK) && !need_word) win_rdata_r <= win_mem[slot_r];
  end

  // Configuration registers.
  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      RIDX_SEED: prdata = seed_r;
      default:   prdata = {24'd0, limit_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= '0;
      limit_r <= LIMIT_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        RIDX_SEED: seed_r  <= pwdata;
        default:   limit_r <= pwdata[7:0];
      endcase
    end
  end

  assign in_ch.ready  = (state_r == T_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.word  = out_word_r;
  assign out_ch.hit   = out_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      base_r      <= '0;
      fill_r      <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != T_DONE)) out_valid_r <= 1'b0;
      case (state_r)
        T_IDLE: begin
          if (in_ch.valid) begin
            act_r   <= in_ch.action;
            seq_r   <= in_ch.sequence_req;
            state_r <= T_EVAL;
          end
        end
        T_EVAL: begin
          res_word_r <= '0;
          res_hit_r  <= 1'b0;
          off_r      <= off_w;
          state_r    <= T_DONE;
          case (act_r)
            ACT_GET: if (in_get) state_r <= T_CHK;
            ACT_PURGE: begin
              if (in_pur) begin
                fill_r <= fill_r - n_w;
                head_r <= head_n;
                base_r <= {1'b0, seq_r} + 33'd1;
              end
            end
            ACT_RESTART: begin
              fill_r  <= '0;
              head_r  <= '0;
              base_r  <= BASE_START;
              state_r <= T_RWAIT;
            end
            default: ;
          endcase
        end
        T_CHK: state_r <= need_word ? T_GWAIT : T_RD;
        T_GWAIT: begin
          if (gen_rsp.done) begin
            fill_r  <= fill_r + FW'(1);
            state_r <= T_CHK;
          end
        end
        T_RD: begin
          res_word_r <= win_rdata_r;
          res_hit_r  <= 1'b1;
          state_r    <= T_DONE;
        end
        T_RWAIT: if (gen_rsp.done) state_r <= T_DONE;
        T_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_word_r  <= res_word_r;
            out_hit_r   <= res_hit_r;
            state_r     <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(WINDOW_DEPTH))
    else $error("window fill exceeds depth");

  a_req_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (gen_req.next || gen_req.restart) |-> !gen_rsp.busy)
    else $error("generator request while busy");

  a_hit_base: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == T_DONE) && res_hit_r |-> (base_r != '0))
    else $error("hit without initialized window");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == T_DONE) && !res_hit_r |-> (res_word_r == '0))
    else $error("miss with nonzero word");
`endif

endmodule

@@ sim/ikw_window_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikw_window_checker
// Watches the request, result and register ports of the keystream window,
// predicts every result word from its own ISAAC generator and window ring,
// and compares the results in order.
// ----------------------------------------------------------------------------
module ikw_window_checker
  import ikw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ikw_in_if           in_ch,
  ikw_out_if          out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending,
  output int          hit_count,
  output int          word_count
);

  localparam int RING      = WINDOW_DEPTH_DEF;
  localparam int EXP_DEPTH = 16;

  typedef struct packed {
    logic [31:0] word;
    logic        hit;
  } window_result_t;

  // Predicted words wait here in order until the block hands out its result.
  window_result_t expected_words [EXP_DEPTH];
  int             exp_wr;
  int             exp_rd;

  logic [31:0] seed_reg;
  logic [7:0]  limit_reg;
  logic [31:0] mix_mem [256];
  logic [31:0] res_words [256];
  logic [31:0] acc_a, acc_b, acc_c;
  logic [7:0]  rd_ptr;
  logic [31:0] ring_words [RING];
  logic [32:0] base;
  int          fill;
  int          head;
  logic [31:0] gv [8];

  task automatic golden_mix();
    int amt [8] = '{11, 2, 8, 16, 10, 4, 8, 9};
    logic [31:0] nb, sh;
    for (int k = 0; k < 8; k++) begin
      nb = gv[(k + 1) & 7];
      sh = (k & 1) ? (nb >> amt[k]) : (nb << amt[k]);
      gv[k] = gv[k] ^ sh;
      gv[(k + 3) & 7] = gv[(k + 3) & 7] + gv[k];
      gv[(k + 1) & 7] = gv[(k + 1) & 7] + gv[(k + 2) & 7];
    end
  endtask

  task automatic scramble();
    logic [31:0] a, b, x, y, sh;
    acc_c = acc_c + 32'd1;
    b = acc_b + acc_c;
    a = acc_a;
    for (int i = 0; i < 256; i++) begin
      x = mix_mem[i];
      case (i & 3)
        0:       sh = a << 13;
        1:       sh = a >> 6;
        2:       sh = a << 2;
        default: sh = a >> 16;
      endcase
      a = (a ^ sh) + mix_mem[(i + 128) & 255];
      y = mix_mem[(x >> 2) & 255] + a + b;
      mix_mem[i] = y;
      b = mix_mem[(y >> 10) & 255] + x;
      res_words[i] = b;
    end
    acc_b = b;
    acc_a = a;
  endtask

  task automatic restart_generator();
    for (int i = 0; i < 256; i++) res_words[i] = '0;
    acc_a = seed_reg;
    acc_b = seed_reg;
    acc_c = seed_reg;
    for (int j = 0; j < 8; j++) gv[j] = GOLDEN;
    for (int i = 0; i < 4; i++) golden_mix();
    for (int pass = 0; pass < 2; pass++) begin
      for (int i = 0; i < 256; i += 8) begin
        for (int j = 0; j < 8; j++)
          gv[j] = gv[j] + (pass ? mix_mem[i + j] : res_words[i + j]);
        golden_mix();
        for (int j = 0; j < 8; j++) mix_mem[i + j] = gv[j];
      end
    end
    scramble();
    rd_ptr = 8'd255;
  endtask

  task automatic pull_word(output logic [31:0] w);
    w = res_words[rd_ptr];
    if (rd_ptr > 0) begin
      rd_ptr = rd_ptr - 8'd1;
    end else begin
      scramble();
      rd_ptr = 8'd255;
    end
  endtask

  task automatic predict_word(input action_t act, input logic [31:0] seq,
                              output window_result_t r);
    logic [32:0] s, lim;
    int off;
    s = {1'b0, seq};
    r = '0;
    lim = (33'(limit_reg) < 33'(RING)) ? 33'(limit_reg) : 33'(RING);
    case (act)
      ACT_GET: begin
        if (base != 0 && s >= base && s < base + lim) begin
          off = int'(s - base);
          while (off >= fill) begin
            pull_word(ring_words[(head + fill) % RING]);
            fill++;
          end
          r.word = ring_words[(head + off) % RING];
          r.hit = 1'b1;
        end
      end
      ACT_PURGE: begin
        if (base != 0 && s >= base && s < base + fill) begin
          off = int'(s - base) + 1;
          fill -= off;
          head = (head + off) % RING;
          base = s + 33'd1;
        end
      end
      ACT_RESTART: begin
        restart_generator();
        fill = 0;
        head = 0;
        base = BASE_START;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    window_result_t exp_r;
    if (!rst_n) begin
      seed_reg = '0;
      limit_reg = LIMIT_RESET;
      acc_a = '0;
      acc_b = '0;
      acc_c = '0;
      rd_ptr = 8'd255;
      base = '0;
      fill = 0;
      head = 0;
      for (int i = 0; i < 256; i++) begin
        mix_mem[i] = '0;
        res_words[i] = '0;
      end
      exp_wr = 0;
      exp_rd = 0;
      fail_count = 0;
      hit_count = 0;
      word_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == RIDX_SEED) seed_reg = pwdata;
        else limit_reg = pwdata[7:0];
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_word(action_t'(in_ch.action), in_ch.sequence_req, exp_r);
        if (exp_wr - exp_rd >= EXP_DEPTH) begin
          $display("%0t: too many words outstanding, expected at most %0d actual %0d",
                   $time, EXP_DEPTH, exp_wr - exp_rd + 1);
          fail_count++;
        end else begin
          expected_words[exp_wr % EXP_DEPTH] = exp_r;
          exp_wr++;
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        word_count++;
        if (exp_wr == exp_rd) begin
          $display("%0t: expected no word, actual word %h hit %b",
                   $time, out_ch.word, out_ch.hit);
          fail_count++;
        end else begin
          exp_r = expected_words[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (out_ch.hit) hit_count++;
          if (out_ch.word !== exp_r.word) begin
            $display("%0t: word expected %h actual %h", $time, exp_r.word, out_ch.word);
            fail_count++;
          end
          if (out_ch.hit !== exp_r.hit) begin
            $display("%0t: hit expected %b actual %b", $time, exp_r.hit, out_ch.hit);
            fail_count++;
          end
        end
      end
    end
    pending = exp_wr - exp_rd;
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives requests and register writes into the keystream window under
// several idle and stall patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import ikw_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending, hit_count, word_count;
  int          send_idle = 0, recv_stall = 0;
  int          hold_req = 0, hold_seen = 0, hold_cycles = 0;
  int          items_sent = 0, restarts = 0;
  logic [32:0] t_base = '0;
  int          t_fill = 0;
  int          t_lim = 100;

  ikw_in_if  in_ch ();
  ikw_out_if out_ch ();

  isaac_keystream_window dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ikw_window_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count),
    .pending(pending), .hit_count(hit_count), .word_count(word_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The receiver; a long hold-off counts down here while the sender goes on.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cycles <= 400;
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  initial begin
    #200ms;
    $display("timeout with %0d words outstanding", pending);
    $display("testbench NOT OK");
    $finish;
  end

  task automatic reg_write(input logic [0:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == RIDX_LIMIT)
      t_lim = (val[7:0] < WINDOW_DEPTH_DEF) ? val[7:0] : WINDOW_DEPTH_DEF;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Mirrors only the window bookkeeping, to aim requests near the base.
  task automatic send(input action_t act, input logic [31:0] seq);
    logic [32:0] s;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.sequence_req <= seq;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    s = {1'b0, seq};
    if (act == ACT_RESTART) begin
      t_base = BASE_START;
      t_fill = 0;
      restarts++;
    end else if (act == ACT_GET && t_base != 0 && s >= t_base && s < t_base + t_lim) begin
      if (int'(s - t_base) >= t_fill) t_fill = int'(s - t_base) + 1;
    end else if (act == ACT_PURGE && t_base != 0 && s >= t_base && s < t_base + t_fill) begin
      t_fill -= int'(s - t_base) + 1;
      t_base = s + 33'd1;
    end
  endtask

  task automatic random_item();
    int r;
    logic [31:0] b;
    r = $urandom_range(999);
    b = t_base[31:0];
    if (r < 8) send(ACT_RESTART, $urandom);
    else if (r < 40) send(action_t'($urandom_range(3)), $urandom);
    else if (r < 70) send(ACT_NONE, $urandom);
    else if (r < 250) send(ACT_PURGE, b + $urandom_range(t_fill + 2) - 1);
    else send(ACT_GET, b + $urandom_range(t_lim + 4) - 2);
  endtask

  task automatic idle_idle(input int pct_s, input int pct_r);
    send_idle = pct_s;
    recv_stall = pct_r;
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_NONE;
    in_ch.sequence_req <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Before any restart the window is not initialized.
    send(ACT_GET, 32'd2);
    send(ACT_PURGE, 32'd2);
    send(ACT_NONE, 32'hFFFF_FFFF);
    in_ch.valid <= 1'b0;
    drain();
    reg_write(RIDX_SEED, 32'h0);
    send(ACT_RESTART, 32'h0);
    send(ACT_GET, 32'd2);
    send(ACT_GET, 32'd1);
    send(ACT_GET, 32'd0);
    send(ACT_GET, 32'd101);
    send(ACT_GET, 32'd102);
    send(ACT_GET, 32'd50);
    send(ACT_PURGE, 32'd200);
    send(ACT_PURGE, 32'd1);
    send(ACT_PURGE, 32'd10);
    send(ACT_GET, 32'd10);
    send(ACT_GET, 32'd11);
    send(ACT_GET, 32'hFFFF_FFFF);
    send(ACT_PURGE, 32'hFFFF_FFFF);
    in_ch.valid <= 1'b0;
    drain();
    reg_write(RIDX_SEED, 32'hFFFF_FFFF);
    reg_write(RIDX_LIMIT, 32'd1);
    send(ACT_RESTART, 32'h0);
    send(ACT_GET, 32'd2);
    send(ACT_GET, 32'd3);
    send(ACT_PURGE, 32'd2);
    send(ACT_GET, 32'd3);
    in_ch.valid <= 1'b0;
    drain();
    reg_write(RIDX_LIMIT, 32'd0);
    send(ACT_GET, 32'd4);
    in_ch.valid <= 1'b0;
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      reg_write(RIDX_SEED, $urandom);
      case (ph)
        0: reg_write(RIDX_LIMIT, 32'd128);
        1: reg_write(RIDX_LIMIT, 32'd255);
        2: reg_write(RIDX_LIMIT, 32'd1);
        default: reg_write(RIDX_LIMIT, $urandom_range(255));
      endcase
      case (ph % 4)
        0: idle_idle(0, 0);
        1: idle_idle(67, 0);
        2: idle_idle(0, 67);
        default: idle_idle(21, 21);
      endcase
      send(ACT_RESTART, $urandom);
      if (ph == 4) hold_req++;
      for (int n = 0; n < 135; n++) random_item();
      in_ch.valid <= 1'b0;
      drain();
    end

    $display("%0d requests sent, %0d restarts, %0d words returned, %0d hits",
             items_sent, restarts, word_count, hit_count);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
